[design/gbfr_pkg.sv]
// Shared constants, types and the field read-out table of the frame receiver.
`default_nettype none

package gbfr_pkg;

	// Frame layout
	localparam int unsigned FRAME_LEN = 60;
	localparam int unsigned IDX_W = 6;
	localparam logic [IDX_W-1:0] LAST_IDX = 6'(FRAME_LEN - 1);
	localparam logic [IDX_W-1:0] SYNC1_IDX = 6'd1;
	localparam logic [IDX_W-1:0] CLASS_IDX = 6'd2;
	localparam logic [IDX_W-1:0] ID_IDX = 6'd3;
	localparam logic [IDX_W-1:0] CK_FIRST = 6'd2;
	localparam logic [IDX_W-1:0] CK_LAST = 6'd57;
	localparam logic [IDX_W-1:0] CK_A_IDX = 6'd58;

	// Sync and message id words, low byte first on the wire
	localparam logic [15:0] SYNC_WORD = 16'h62b5;
	localparam logic [15:0] MSG_ID_WORD = 16'h0601;

	// Frame offsets of the decoded fields (payload starts at frame byte 6)
	localparam logic [IDX_W-1:0] F_TOW = 6'd6;
	localparam logic [IDX_W-1:0] F_WEEK = 6'd14;
	localparam logic [IDX_W-1:0] F_FIX = 6'd16;
	localparam logic [IDX_W-1:0] F_X = 6'd18;
	localparam logic [IDX_W-1:0] F_Y = 6'd22;
	localparam logic [IDX_W-1:0] F_Z = 6'd26;
	localparam logic [IDX_W-1:0] F_ACC = 6'd30;
	localparam logic [IDX_W-1:0] F_SATS = 6'd53;

	// Frame memory: two banks of 64 bytes, bank select on the top address bit
	localparam int unsigned RAM_DEPTH = 128;
	localparam int unsigned RAM_AW = $clog2(RAM_DEPTH);

	// Number of frame bytes read back per frame
	localparam int unsigned NUM_READS = 24;
	localparam int unsigned RD_CNT_W = $clog2(NUM_READS);
	localparam logic [RD_CNT_W-1:0] LAST_READ = RD_CNT_W'(NUM_READS - 1);

	// Frame status codes
	localparam logic [1:0] ST_VALID = 2'd0;
	localparam logic [1:0] ST_BAD_ID = 2'd1;
	localparam logic [1:0] ST_BAD_CK = 2'd2;

	// Handoff from the byte collector to the read-out engine
	typedef struct packed {
		logic       start;
		logic       bank;
		logic [1:0] status;
	} frame_done_t;

	// Decoded navigation solution
	typedef struct packed {
		logic [1:0]         frame_status;
		logic [31:0]        time_of_week_ms;
		logic signed [15:0] week_number;
		logic [7:0]         fix_type;
		logic signed [31:0] ecef_x_cm;
		logic signed [31:0] ecef_y_cm;
		logic signed [31:0] ecef_z_cm;
		logic [31:0]        position_accuracy_cm;
		logic [7:0]         satellite_count;
	} nav_sol_t;

	// Frame offset of the n-th byte to read back
	function automatic logic [IDX_W-1:0] read_addr(input logic [RD_CNT_W-1:0] n);
		logic [IDX_W-1:0] nx;
		logic [IDX_W-1:0] a;
		nx = {1'b0, n};
		if (n < 5'd4) begin
			a = F_TOW + nx;
		end else if (n < 5'd6) begin
			a = F_WEEK + (nx - 6'd4);
		end else if (n == 5'd6) begin
			a = F_FIX;
		end else if (n < 5'd23) begin
			a = F_X + (nx - 6'd7);
		end else begin
			a = F_SATS;
		end
		return a;
	endfunction

endpackage

`default_nettype wire

[design/gbfr_in_if.sv]
// Input channel: one received serial byte per item.
`default_nettype none

interface gbfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[design/gbfr_out_if.sv]
// Output channel: one decoded navigation frame per item.
`default_nettype none

interface gbfr_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         frame_status;
	logic [31:0]        time_of_week_ms;
	logic signed [15:0] week_number;
	logic [7:0]         fix_type;
	logic signed [31:0] ecef_x_cm;
	logic signed [31:0] ecef_y_cm;
	logic signed [31:0] ecef_z_cm;
	logic [31:0]        position_accuracy_cm;
	logic [7:0]         satellite_count;

	modport source(output valid, input ready, output frame_status, output time_of_week_ms,
		output week_number, output fix_type, output ecef_x_cm, output ecef_y_cm,
		output ecef_z_cm, output position_accuracy_cm, output satellite_count);
	modport sink(input valid, output ready, input frame_status, input time_of_week_ms,
		input week_number, input fix_type, input ecef_x_cm, input ecef_y_cm,
		input ecef_z_cm, input position_accuracy_cm, input satellite_count);
endinterface

`default_nettype wire

[design/gbfr_ram.sv]
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none

module gbfr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[design/gbfr_readout.sv]
// Read-out engine: fetches the field bytes of a finished frame and holds the result item.
`default_nettype none

module gbfr_readout (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire gbfr_pkg::frame_done_t          done,
	output      logic                           busy,
	output      logic                           rd_en,
	output      logic [gbfr_pkg::RAM_AW-1:0]    rd_addr,
	input  wire logic [7:0]                     rd_data,
	gbfr_out_if.source                          nav
);

	logic                              reading_q;
	logic [gbfr_pkg::RD_CNT_W-1:0]     cnt_q;
	logic                              bank_q;
	logic                              rd_en_s1;
	logic                              last_s1;
	logic [gbfr_pkg::IDX_W-1:0]        fidx_s1;
	logic                              full_q;
	logic                              out_valid_q;
	gbfr_pkg::nav_sol_t                asm_q;
	gbfr_pkg::nav_sol_t                out_q;
	logic [gbfr_pkg::IDX_W-1:0]        fidx;
	logic [1:0]                        lane;
	logic                              handoff;

	// Address of the current read
	assign fidx = gbfr_pkg::read_addr(cnt_q);
	assign rd_en = reading_q;
	assign rd_addr = {bank_q, fidx};

	// Byte lane inside a 32-bit field: all 4-byte fields start at offset 2 mod 4
	assign lane = fidx_s1[1:0] - 2'd2;

	assign handoff = full_q && (!out_valid_q || nav.ready);
	assign busy = reading_q || rd_en_s1 || full_q;

	// Read sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reading_q <= 1'b0;
			cnt_q <= '0;
			bank_q <= 1'b0;
			rd_en_s1 <= 1'b0;
			last_s1 <= 1'b0;
			full_q <= 1'b0;
		end else begin
			rd_en_s1 <= reading_q;
			last_s1 <= reading_q && (cnt_q == gbfr_pkg::LAST_READ);
			if (done.start) begin
				reading_q <= 1'b1;
				cnt_q <= '0;
				bank_q <= done.bank;
			end else if (reading_q) begin
				if (cnt_q == gbfr_pkg::LAST_READ) begin
					reading_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
			if (rd_en_s1 && last_s1) begin
				full_q <= 1'b1;
			end else if (handoff) begin
				full_q <= 1'b0;
			end
		end
	end

	// Offset of the byte in flight
	always_ff @(posedge clk) begin
		fidx_s1 <= fidx;
	end

	// Field assembly from returned bytes
	always_ff @(posedge clk) begin
		if (done.start) begin
			asm_q.frame_status <= done.status;
		end
		if (rd_en_s1) begin
			case (fidx_s1) inside
				[gbfr_pkg::F_TOW:gbfr_pkg::F_TOW + 6'd3]:
					asm_q.time_of_week_ms[{lane, 3'b000} +: 8] <= rd_data;
				[gbfr_pkg::F_WEEK:gbfr_pkg::F_WEEK + 6'd1]:
					asm_q.week_number[{lane[0], 3'b000} +: 8] <= rd_data;
				gbfr_pkg::F_FIX:
					asm_q.fix_type <= rd_data;
				[gbfr_pkg::F_X:gbfr_pkg::F_X + 6'd3]:
					asm_q.ecef_x_cm[{lane, 3'b000} +: 8] <= rd_data;
				[gbfr_pkg::F_Y:gbfr_pkg::F_Y + 6'd3]:
					asm_q.ecef_y_cm[{lane, 3'b000} +: 8] <= rd_data;
				[gbfr_pkg::F_Z:gbfr_pkg::F_Z + 6'd3]:
					asm_q.ecef_z_cm[{lane, 3'b000} +: 8] <= rd_data;
				[gbfr_pkg::F_ACC:gbfr_pkg::F_ACC + 6'd3]:
					asm_q.position_accuracy_cm[{lane, 3'b000} +: 8] <= rd_data;
				gbfr_pkg::F_SATS:
					asm_q.satellite_count <= rd_data;
				default: begin
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (handoff) begin
			out_valid_q <= 1'b1;
		end else if (nav.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (handoff) begin
			out_q <= asm_q;
		end
	end

	assign nav.valid = out_valid_q;
	assign nav.frame_status = out_q.frame_status;
	assign nav.time_of_week_ms = out_q.time_of_week_ms;
	assign nav.week_number = out_q.week_number;
	assign nav.fix_type = out_q.fix_type;
	assign nav.ecef_x_cm = out_q.ecef_x_cm;
	assign nav.ecef_y_cm = out_q.ecef_y_cm;
	assign nav.ecef_z_cm = out_q.ecef_z_cm;
	assign nav.position_accuracy_cm = out_q.position_accuracy_cm;
	assign nav.satellite_count = out_q.satellite_count;

endmodule

`default_nettype wire

[design/gnss_binary_frame_receiver.sv]
// Top level of the GNSS binary navigation-solution frame receiver.
// The receiver takes one serial byte per cycle and collects 60-byte frames that open with
// the sync bytes 0xB5 0x62; a byte that breaks sync is dropped and the hunt restarts with
// the following byte. Each accepted frame byte is written into a 128x8 frame memory split
// into two 64-byte banks, so one frame fills a bank while the previous one is read back.
// Class/id and the 8-bit Fletcher checksum over bytes 2..57 are checked on the fly as the
// bytes pass. After the last byte the read-out engine fetches the 24 field bytes through
// the memory's single read port, one per cycle, and assembles them into one result item.
// Input is taken every cycle; it stalls only when the last byte of a frame arrives
// while the read-out engine still holds the previous frame's result because an
// older result item waits untaken at the output.
// Status 0 is a good frame, 1 a wrong class or id (checked first), 2 a checksum mismatch;
// the fields are reported either way. The memory needs no clearing after reset.
`default_nettype none

module gnss_binary_frame_receiver (
	input wire logic   clk,
	input wire logic   arst_n,
	gbfr_in_if.sink    rx,
	gbfr_out_if.source nav
);

	logic [gbfr_pkg::IDX_W-1:0] idx_q;
	logic [7:0]                 sum_a_q;
	logic [7:0]                 sum_b_q;
	logic                       bank_q;
	logic                       class_ok_q;
	logic                       id_ok_q;
	logic                       ck_a_ok_q;
	logic [7:0]                 c;
	logic                       accept;
	logic                       take;
	logic                       last;
	logic                       in_ck;
	logic [7:0]                 sum_a_nxt;
	logic [7:0]                 sum_b_nxt;
	logic                       busy;
	logic                       rd_en;
	logic [gbfr_pkg::RAM_AW-1:0] rd_addr;
	logic [7:0]                 rd_data;
	gbfr_pkg::frame_done_t      done;

	assign c = rx.rx_byte;
	assign accept = rx.valid && rx.ready;
	assign last = (idx_q == gbfr_pkg::LAST_IDX);

	// Sync check on the first two bytes; out-of-range index falls back to hunting
	always_comb begin
		if (idx_q == '0) begin
			take = (c == gbfr_pkg::SYNC_WORD[7:0]);
		end else if (idx_q == gbfr_pkg::SYNC1_IDX) begin
			take = (c == gbfr_pkg::SYNC_WORD[15:8]);
		end else begin
			take = (idx_q <= gbfr_pkg::LAST_IDX);
		end
	end

	// Running Fletcher sums
	assign in_ck = (idx_q >= gbfr_pkg::CK_FIRST) && (idx_q <= gbfr_pkg::CK_LAST);
	assign sum_a_nxt = sum_a_q + c;
	assign sum_b_nxt = sum_b_q + sum_a_nxt;

	// Stall the closing byte while the read-out engine still holds a frame
	assign rx.ready = !(last && busy);

	// Frame completion and status
	always_comb begin
		done.start = accept && take && last;
		done.bank = bank_q;
		if (!id_ok_q) begin
			done.status = gbfr_pkg::ST_BAD_ID;
		end else if (!ck_a_ok_q || (c != sum_b_q)) begin
			done.status = gbfr_pkg::ST_BAD_CK;
		end else begin
			done.status = gbfr_pkg::ST_VALID;
		end
	end

	// Byte index, sums and bank select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
			bank_q <= 1'b0;
		end else if (accept) begin
			if (!take) begin
				idx_q <= '0;
			end else if (last) begin
				idx_q <= '0;
				sum_a_q <= '0;
				sum_b_q <= '0;
				bank_q <= !bank_q;
			end else begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == '0) begin
					sum_a_q <= '0;
					sum_b_q <= '0;
				end else if (in_ck) begin
					sum_a_q <= sum_a_nxt;
					sum_b_q <= sum_b_nxt;
				end
			end
		end
	end

	// Header and checksum flags, captured as their bytes pass
	always_ff @(posedge clk) begin
		if (accept && take) begin
			if (idx_q == gbfr_pkg::CLASS_IDX) begin
				class_ok_q <= (c == gbfr_pkg::MSG_ID_WORD[7:0]);
			end
			if (idx_q == gbfr_pkg::ID_IDX) begin
				id_ok_q <= class_ok_q && (c == gbfr_pkg::MSG_ID_WORD[15:8]);
			end
			if (idx_q == gbfr_pkg::CK_A_IDX) begin
				ck_a_ok_q <= (c == sum_a_q);
			end
		end
	end

	// Frame memory
	gbfr_ram #(
		.WIDTH(8),
		.DEPTH(gbfr_pkg::RAM_DEPTH)
	) u_frame_ram (
		.clk  (clk),
		.we   (accept && take),
		.waddr({bank_q, idx_q}),
		.wdata(c),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	gbfr_readout u_readout (
		.clk    (clk),
		.arst_n (arst_n),
		.done   (done),
		.busy   (busy),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.nav    (nav)
	);

endmodule

`default_nettype wire

[design/gbfr_checker.sv]
// Port-level checks of the frame receiver, bound to the top level.
`default_nettype none

module gbfr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        rx_ready,
	input wire logic        nav_valid,
	input wire logic        nav_ready,
	input wire logic [1:0]  frame_status,
	input wire logic [31:0] time_of_week_ms,
	input wire logic [31:0] ecef_x_cm,
	input wire logic [7:0]  satellite_count
);

	// A result item stays offered until taken
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		nav_valid && !nav_ready |=> nav_valid)
		else $error("result item withdrawn before it was taken");

	// A stalled result item keeps its contents
	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		nav_valid && !nav_ready |=> $stable(frame_status) && $stable(time_of_week_ms)
			&& $stable(ecef_x_cm) && $stable(satellite_count))
		else $error("result item changed while stalled");

	// Only the three defined status codes are reported
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		nav_valid |-> frame_status != 2'd3)
		else $error("undefined frame status");

	// Input stalls only behind an unclaimed result item
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> nav_valid)
		else $error("input stalled with no result pending");

endmodule

bind gnss_binary_frame_receiver gbfr_checker u_gbfr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rx_ready       (rx.ready),
	.nav_valid      (nav.valid),
	.nav_ready      (nav.ready),
	.frame_status   (nav.frame_status),
	.time_of_week_ms(nav.time_of_week_ms),
	.ecef_x_cm      (nav.ecef_x_cm),
	.satellite_count(nav.satellite_count)
);

`default_nettype wire

[dv/gbfr_frame_checker.sv]
// Frame receiver checker: predicts decoded navigation frames from the byte stream and compares.
module gbfr_frame_checker
	import gbfr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	gbfr_in_if   rx,
	gbfr_out_if  nav,
	output int   fail_count,
	output int   pending,
	output int   predicted
);
	timeunit 1ns;
	timeprecision 1ps;

	// Frame positions
	localparam logic [5:0] SYNC0_POS = 6'd0;
	localparam logic [5:0] SYNC1_POS = 6'd1;
	localparam logic [5:0] SUM_FIRST_POS = 6'd2;
	localparam logic [5:0] SUM_LAST_POS = 6'd57;
	localparam logic [5:0] FINAL_POS = 6'd59;
	localparam int unsigned CLASS_POS = 2;
	localparam int unsigned ID_POS = 3;
	localparam int unsigned SUM_A_POS = 58;
	localparam int unsigned SUM_B_POS = 59;
	localparam int unsigned PAY_OFS = 6;

	// Predicted parser state
	logic [5:0] frame_pos;
	logic [7:0] fletcher_a;
	logic [7:0] fletcher_b;
	logic [7:0] frame_bytes [FRAME_LEN];

	// Decoded frames still owed by the block, oldest first
	nav_sol_t owed_solutions [$];

	function automatic logic [31:0] le32(input int unsigned pos);
		return {frame_bytes[pos+3], frame_bytes[pos+2], frame_bytes[pos+1], frame_bytes[pos]};
	endfunction

	// Advance the parser by one received byte; queue a decoded frame on its last byte
	task automatic absorb_byte(input logic [7:0] c);
		logic accept;
		nav_sol_t sol;
		if (frame_pos == SYNC0_POS) begin
			accept = (c == SYNC_WORD[7:0]);
		end else if (frame_pos == SYNC1_POS) begin
			accept = (c == SYNC_WORD[15:8]);
		end else begin
			accept = (frame_pos <= FINAL_POS);
		end

		if (!accept) begin
			// sync lost: hunt again from the next byte
			frame_pos = SYNC0_POS;
		end else begin
			frame_bytes[frame_pos] = c;
			if (frame_pos == SYNC0_POS) begin
				fletcher_a = '0;
				fletcher_b = '0;
			end
			if (frame_pos >= SUM_FIRST_POS && frame_pos <= SUM_LAST_POS) begin
				fletcher_a = fletcher_a + c;
				fletcher_b = fletcher_b + fletcher_a;
			end

			if (frame_pos != FINAL_POS) begin
				frame_pos = frame_pos + 6'd1;
			end else begin
				// class/id wins over checksum
				if ({frame_bytes[ID_POS], frame_bytes[CLASS_POS]} != MSG_ID_WORD) begin
					sol.frame_status = ST_BAD_ID;
				end else if (frame_bytes[SUM_A_POS] != fletcher_a
						|| frame_bytes[SUM_B_POS] != fletcher_b) begin
					sol.frame_status = ST_BAD_CK;
				end else begin
					sol.frame_status = ST_VALID;
				end
				sol.time_of_week_ms = le32(PAY_OFS);
				sol.week_number = {frame_bytes[PAY_OFS+9], frame_bytes[PAY_OFS+8]};
				sol.fix_type = frame_bytes[PAY_OFS+10];
				sol.ecef_x_cm = le32(PAY_OFS + 12);
				sol.ecef_y_cm = le32(PAY_OFS + 16);
				sol.ecef_z_cm = le32(PAY_OFS + 20);
				sol.position_accuracy_cm = le32(PAY_OFS + 24);
				sol.satellite_count = frame_bytes[PAY_OFS+47];
				owed_solutions.push_back(sol);
				predicted++;
				frame_pos = SYNC0_POS;
				fletcher_a = '0;
				fletcher_b = '0;
			end
		end
	endtask

	task automatic check_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t mismatch %s: expected %h actual %h", $time, fname, want, got);
			fail_count++;
		end
	endtask

	// Compare one delivered item against the oldest owed frame
	task automatic compare_solution();
		nav_sol_t want;
		if (owed_solutions.size() == 0) begin
			$display("%0t unexpected item: expected none actual status %h tow %h", $time,
				nav.frame_status, nav.time_of_week_ms);
			fail_count++;
		end else begin
			want = owed_solutions.pop_front();
			check_field("frame_status", want.frame_status, nav.frame_status);
			check_field("time_of_week_ms", want.time_of_week_ms, nav.time_of_week_ms);
			check_field("week_number", want.week_number, nav.week_number);
			check_field("fix_type", want.fix_type, nav.fix_type);
			check_field("ecef_x_cm", want.ecef_x_cm, nav.ecef_x_cm);
			check_field("ecef_y_cm", want.ecef_y_cm, nav.ecef_y_cm);
			check_field("ecef_z_cm", want.ecef_z_cm, nav.ecef_z_cm);
			check_field("position_accuracy_cm", want.position_accuracy_cm,
				nav.position_accuracy_cm);
			check_field("satellite_count", want.satellite_count, nav.satellite_count);
		end
	endtask

	// Watch both channels at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pos = SYNC0_POS;
			fletcher_a = '0;
			fletcher_b = '0;
			owed_solutions.delete();
			fail_count = 0;
			predicted = 0;
		end else begin
			if (nav.valid && nav.ready) begin
				compare_solution();
			end
			if (rx.valid && rx.ready) begin
				absorb_byte(rx.rx_byte);
			end
		end
		pending = owed_solutions.size();
	end

endmodule

[dv/testbench.sv]
// Testbench top: clock, reset, byte stream stimulus, output stalls and the verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import gbfr_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 5;
	localparam int RANDOM_ITEMS = 1100;
	localparam int LONG_HOLD = 1500;
	localparam int DRAIN_CYCLES = 200;
	localparam int TIMEOUT_NS = 10_000_000;
	localparam int unsigned PAY_OFS = 6;
	localparam int unsigned LEN_LO_POS = 4;
	localparam int unsigned LEN_HI_POS = 5;
	localparam logic [7:0] PAYLOAD_LEN = 8'd52;

	typedef enum int {
		FR_GOOD,
		FR_BAD_CLASS,
		FR_BAD_ID,
		FR_BAD_CK_A,
		FR_BAD_CK_B,
		FR_BAD_CK_BOTH,
		FR_BAD_ID_CK
	} frame_kind_e;

	logic clk = 1'b0;
	logic arst_n;
	int fail_count;
	int pending;
	int predicted;
	int bytes_sent;
	logic tx_fast;
	logic [7:0] frame_buf [FRAME_LEN];

	gbfr_in_if rx_ch();
	gbfr_out_if nav_ch();

	gnss_binary_frame_receiver u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.nav(nav_ch)
	);

	gbfr_frame_checker u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.nav(nav_ch),
		.fail_count(fail_count),
		.pending(pending),
		.predicted(predicted)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Offer one byte after a random gap and wait until it is taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < FRAME_LEN; i++) begin
			send_byte(frame_buf[i]);
		end
	endtask

	function automatic logic [7:0] flip_mask();
		return 8'($urandom_range(1, 255));
	endfunction

	// Bytes 4..57: a fixed fill or random content with a usually correct length
	task automatic fill_body(input bit rand_fill, input logic [7:0] fill);
		for (int i = LEN_LO_POS; i <= 57; i++) begin
			frame_buf[i] = rand_fill ? 8'($urandom) : fill;
		end
		if (rand_fill && $urandom_range(0, 3) != 0) begin
			frame_buf[LEN_LO_POS] = PAYLOAD_LEN;
			frame_buf[LEN_HI_POS] = 8'h00;
		end
	endtask

	task automatic put_le(input int unsigned pos, input logic [31:0] v, input int unsigned n);
		for (int unsigned k = 0; k < n; k++) begin
			frame_buf[PAY_OFS+pos+k] = v[8*k +: 8];
		end
	endtask

	// Header, checksum and the requested corruption
	task automatic seal_frame(input frame_kind_e kind);
		logic [7:0] a;
		logic [7:0] b;
		frame_buf[0] = SYNC_WORD[7:0];
		frame_buf[1] = SYNC_WORD[15:8];
		frame_buf[2] = MSG_ID_WORD[7:0];
		frame_buf[3] = MSG_ID_WORD[15:8];
		if (kind == FR_BAD_CLASS) begin
			frame_buf[2] = frame_buf[2] ^ flip_mask();
		end
		if (kind == FR_BAD_ID || kind == FR_BAD_ID_CK) begin
			frame_buf[3] = frame_buf[3] ^ flip_mask();
		end
		a = '0;
		b = '0;
		for (int i = 2; i <= 57; i++) begin
			a = a + frame_buf[i];
			b = b + a;
		end
		frame_buf[58] = a;
		frame_buf[59] = b;
		if (kind == FR_BAD_CK_A || kind == FR_BAD_CK_BOTH || kind == FR_BAD_ID_CK) begin
			frame_buf[58] = frame_buf[58] ^ flip_mask();
		end
		if (kind == FR_BAD_CK_B || kind == FR_BAD_CK_BOTH) begin
			frame_buf[59] = frame_buf[59] ^ flip_mask();
		end
	endtask

	task automatic send_random_frame(input frame_kind_e kind);
		fill_body(1'b1, 8'h00);
		seal_frame(kind);
		send_frame();
	endtask

	// Random bytes; the last one never opens a frame
	task automatic send_noise(input int n);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom);
			if (i == n - 1 && b == SYNC_WORD[7:0]) begin
				b = ~b;
			end
			send_byte(b);
		end
	endtask

	// Sync breaks and frames cut short
	task automatic send_broken_sync();
		logic [7:0] b;
		case ($urandom_range(0, 2))
			0: begin
				send_byte(SYNC_WORD[7:0]);
				b = 8'($urandom);
				if (b == SYNC_WORD[15:8]) begin
					b = b ^ flip_mask();
				end
				send_byte(b);
			end
			1: begin
				send_byte(SYNC_WORD[7:0]);
				send_byte(SYNC_WORD[7:0]);
				send_byte(SYNC_WORD[15:8]);
			end
			default: begin
				// truncated frame: the parser swallows what follows as the rest of it
				fill_body(1'b1, 8'h00);
				seal_frame(FR_GOOD);
				for (int i = 0; i < $urandom_range(2, 40); i++) begin
					send_byte(frame_buf[i]);
				end
			end
		endcase
	endtask

	function automatic frame_kind_e pick_kind();
		frame_kind_e k;
		case ($urandom_range(0, 9))
			6: k = FR_BAD_CLASS;
			7: k = FR_BAD_ID;
			8: begin
				case ($urandom_range(0, 2))
					0: k = FR_BAD_CK_A;
					1: k = FR_BAD_CK_B;
					default: k = FR_BAD_CK_BOTH;
				endcase
			end
			9: k = FR_BAD_ID_CK;
			default: k = FR_GOOD;
		endcase
		return k;
	endfunction

	// Receiver: random stalls, fast stretches and occasional long hold-offs
	initial begin
		int gap;
		int taken;
		logic rx_fast_mode;
		nav_ch.ready = 1'b0;
		taken = 0;
		rx_fast_mode = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken == 2 || (taken > 2 && $urandom_range(0, 29) == 0)) begin
				nav_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if ($urandom_range(0, 9) == 0) begin
				rx_fast_mode = !rx_fast_mode;
			end
			gap = rx_fast_mode ? 0 : $urandom_range(0, 11);
			if (gap > 0) begin
				nav_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			nav_ch.ready <= 1'b1;
			@(posedge clk);
			while (!nav_ch.valid) @(posedge clk);
			taken++;
		end
	end

	// Stimulus and verdict
	initial begin
		int start_count;
		int pick;
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'h00;
		tx_fast = 1'b0;
		bytes_sent = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray bytes, broken sync, then a second 0xB5 that must not resync
		send_byte(SYNC_WORD[15:8]);
		send_byte(SYNC_WORD[7:0]);
		send_byte(8'h00);
		send_byte(SYNC_WORD[7:0]);
		send_byte(SYNC_WORD[7:0]);
		send_byte(SYNC_WORD[15:8]);

		// all-zero and all-ones bodies
		fill_body(1'b0, 8'h00);
		seal_frame(FR_GOOD);
		send_frame();
		send_byte(8'hff);
		fill_body(1'b0, 8'hff);
		seal_frame(FR_GOOD);
		send_frame();

		// signed and unsigned field extremes, back to back
		tx_fast = 1'b1;
		fill_body(1'b1, 8'h00);
		put_le(0, 32'h0000_0000, 4);
		put_le(8, 32'h0000_7fff, 2);
		put_le(10, 32'h0000_00ff, 1);
		put_le(12, 32'h7fff_ffff, 4);
		put_le(16, 32'h8000_0000, 4);
		put_le(20, 32'h0000_0000, 4);
		put_le(24, 32'hffff_ffff, 4);
		put_le(47, 32'h0000_0000, 1);
		seal_frame(FR_GOOD);
		send_frame();
		put_le(0, 32'hffff_ffff, 4);
		put_le(8, 32'h0000_8000, 2);
		put_le(10, 32'h0000_0000, 1);
		put_le(12, 32'h8000_0000, 4);
		put_le(16, 32'h7fff_ffff, 4);
		put_le(20, 32'hffff_ffff, 4);
		put_le(24, 32'h0000_0000, 4);
		put_le(47, 32'h0000_00ff, 1);
		seal_frame(FR_GOOD);
		send_frame();
		tx_fast = 1'b0;

		// each rejection status, and wrong id together with a bad checksum
		send_random_frame(FR_BAD_CLASS);
		send_random_frame(FR_BAD_ID);
		send_random_frame(FR_BAD_CK_A);
		send_random_frame(FR_BAD_CK_B);
		send_random_frame(FR_BAD_CK_BOTH);
		send_random_frame(FR_BAD_ID_CK);

		// random traffic: mostly whole frames, some noise and broken sync
		start_count = bytes_sent;
		while (bytes_sent - start_count < RANDOM_ITEMS) begin
			tx_fast = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				send_random_frame(pick_kind());
			end else if (pick < 90) begin
				send_noise($urandom_range(1, 20));
			end else begin
				send_broken_sync();
			end
		end
		rx_ch.valid <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#TIMEOUT_NS;
		$display("status: fail");
		$finish;
	end

endmodule
